// File: rtl/snpcmf_pkg.sv
// shared types, character codes and the compare function of the column mask filter
`default_nettype none

package snpcmf_pkg;

    // default depth of the position stores
    localparam int unsigned MAX_POSITIONS_DEF = 65536;

    // request modes carried in tuser
    localparam logic [1:0] MODE_REF    = 2'd0;
    localparam logic [1:0] MODE_MASK   = 2'd1;
    localparam logic [1:0] MODE_FILTER = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // character codes
    localparam logic [7:0] CHAR_LF      = 8'd10;
    localparam logic [7:0] CHAR_N_UPPER = 8'd78;
    localparam logic [7:0] CHAR_N_LOWER = 8'd110;
    localparam logic [7:0] CHAR_A_UPPER = 8'd65;
    localparam logic [7:0] CHAR_Z_UPPER = 8'd90;
    localparam logic [7:0] CHAR_A_LOWER = 8'd97;
    localparam logic [7:0] CHAR_Z_LOWER = 8'd122;
    localparam logic [8:0] CASE_OFFSET  = 9'd32;

    // one mask entry per position
    typedef struct packed {
        logic no_n;
        logic diff;
    } mask_entry_t;

    localparam mask_entry_t MASK_RESET = '{no_n: 1'b1, diff: 1'b0};

    // write request into the mask store
    typedef struct packed {
        logic        we;
        mask_entry_t wdata;
    } mask_req_t;

    // true when a sample character differs from the reference character, ignoring letter case
    function automatic logic differs(input logic [7:0] c, input logic [7:0] r);
        logic up;
        logic lo;
        begin
            up = (c >= CHAR_A_UPPER) && (c <= CHAR_Z_UPPER);
            lo = (c >= CHAR_A_LOWER) && (c <= CHAR_Z_LOWER);
            if (c == r) begin
                differs = 1'b0;
            end else if (up) begin
                differs = ({1'b0, r} != ({1'b0, c} + CASE_OFFSET));
            end else if (lo) begin
                differs = (({1'b0, r} + CASE_OFFSET) != {1'b0, c});
            end else begin
                differs = 1'b1;
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/snpcmf_ref_store.sv
// reference character store: one port, registered read
`default_nettype none

module snpcmf_ref_store #(
    parameter int unsigned MAX_POSITIONS = snpcmf_pkg::MAX_POSITIONS_DEF,
    localparam int unsigned AW = $clog2(MAX_POSITIONS)
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [MAX_POSITIONS];
    logic [7:0] rdata_reg;

    // write or read the addressed entry
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/snpcmf_mask_store.sv
// mask store with a clearing pass after reset
`default_nettype none

module snpcmf_mask_store #(
    parameter int unsigned MAX_POSITIONS = snpcmf_pkg::MAX_POSITIONS_DEF,
    localparam int unsigned AW = $clog2(MAX_POSITIONS)
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    rd_en,
    input  wire logic [AW-1:0]           rd_addr,
    input  wire snpcmf_pkg::mask_req_t   req,
    input  wire logic [AW-1:0]           wr_addr,
    output snpcmf_pkg::mask_entry_t      rd_data,
    output logic                         clearing
);

    snpcmf_pkg::mask_entry_t mem [MAX_POSITIONS];
    snpcmf_pkg::mask_entry_t rd_data_reg;
    logic [AW-1:0]           clr_addr_reg;
    logic                    clr_busy_reg;

    // clearing sweep, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(MAX_POSITIONS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // memory write port: sweep first, then requests
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= snpcmf_pkg::MASK_RESET;
        end else if (req.we) begin
            mem[wr_addr] <= req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

`default_nettype wire

// File: rtl/snp_column_mask_filter_unit.sv
// top level of the alignment column mask filter
`default_nettype none

// Filters aligned sequence text down to informative columns. Each request carries one byte
// (s_tdata), a mode (s_tuser: 0 load reference, 1 update masks, 2 filter, 3 ignored) and an
// end-of-sequence flag (s_tlast). The accept cycle reads the
// reference and mask stores at the current position; in ST_EXEC the block computes and writes the
// masks back and loads the result register; a filter result waits there while m_tready is
// low, and ST_EXEC of a request that gives a result is held until that register is
// free or being drained. After every reset the mask store is swept to its reset value over all
// MAX_POSITIONS entries, during which s_tready stays low. Results carry the kept byte in
// m_tdata, a kept flag in m_tuser and the end of the filtered sequence in m_tlast.
module snp_column_mask_filter_unit #(
    parameter int unsigned MAX_POSITIONS = snpcmf_pkg::MAX_POSITIONS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] symbol
    input  wire logic [1:0] s_tuser,   // [1:0] mode
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] out_symbol
    output logic            m_tuser,   // [0] symbol_valid
    output logic            m_tlast
);

    localparam int unsigned AW = $clog2(MAX_POSITIONS);
    localparam int unsigned PW = $clog2(MAX_POSITIONS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                  state_reg;
    logic [PW-1:0]           pos_reg;
    logic [PW-1:0]           ref_len_reg;
    logic [1:0]              mode_reg;
    logic [7:0]              sym_reg;
    logic                    last_reg;
    logic                    in_range_reg;
    logic [AW-1:0]           addr_reg;
    logic                    m_tvalid_reg;
    logic [7:0]              m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    m_tlast_reg;

    logic                    clearing;
    logic                    accept;
    logic                    is_lf;
    logic                    pos_ok;
    logic                    ref_we;
    logic [PW-1:0]           pos_next;
    logic [7:0]              ref_rdata;
    snpcmf_pkg::mask_entry_t mask_rdata;
    snpcmf_pkg::mask_req_t   mask_req;
    logic                    kept;
    logic                    result;
    logic                    out_free;
    logic                    finish;
    logic                    is_n;

    // request side
    assign s_tready = (state_reg == ST_IDLE) && !clearing;
    assign accept   = s_tvalid && s_tready;
    assign is_lf    = (s_tdata == snpcmf_pkg::CHAR_LF);
    assign pos_ok   = (pos_reg < PW'(MAX_POSITIONS));
    assign ref_we   = accept && (s_tuser == snpcmf_pkg::MODE_REF) && !is_lf && pos_ok;

    // next position
    always_comb begin
        pos_next = pos_reg;
        if (s_tuser != snpcmf_pkg::MODE_NONE) begin
            if (!is_lf && pos_ok) begin
                pos_next = pos_reg + 1'b1;
            end
            if (s_tlast) begin
                pos_next = '0;
            end
        end
    end

    snpcmf_ref_store #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) u_ref_store (
        .aclk  (aclk),
        .en    (accept),
        .we    (ref_we),
        .addr  (pos_reg[AW-1:0]),
        .wdata (s_tdata),
        .rdata (ref_rdata)
    );

    // read-modify-write of the masks
    assign is_n     = (sym_reg == snpcmf_pkg::CHAR_N_UPPER) ||
                      (sym_reg == snpcmf_pkg::CHAR_N_LOWER);
    assign kept     = (mode_reg == snpcmf_pkg::MODE_FILTER) && in_range_reg &&
                      (sym_reg != snpcmf_pkg::CHAR_LF) && mask_rdata.no_n && mask_rdata.diff;
    assign result   = (mode_reg == snpcmf_pkg::MODE_FILTER) && (kept || last_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_EXEC) && (!result || out_free);

    always_comb begin
        mask_req.we    = finish && (mode_reg == snpcmf_pkg::MODE_MASK) && in_range_reg &&
                         (sym_reg != snpcmf_pkg::CHAR_LF) && mask_rdata.no_n;
        mask_req.wdata = mask_rdata;
        if (is_n) begin
            mask_req.wdata.no_n = 1'b0;
        end else if (snpcmf_pkg::differs(sym_reg, ref_rdata)) begin
            mask_req.wdata.diff = 1'b1;
        end
    end

    snpcmf_mask_store #(
        .MAX_POSITIONS(MAX_POSITIONS)
    ) u_mask_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (pos_reg[AW-1:0]),
        .req      (mask_req),
        .wr_addr  (addr_reg),
        .rd_data  (mask_rdata),
        .clearing (clearing)
    );

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg     <= s_tuser;
            sym_reg      <= s_tdata;
            last_reg     <= s_tlast;
            in_range_reg <= (pos_reg < ref_len_reg);
            addr_reg     <= pos_reg[AW-1:0];
        end
    end

    // control state, position counters and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            ref_len_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                        pos_reg   <= pos_next;
                        if (ref_we) begin
                            ref_len_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                ST_EXEC: begin
                    if (finish) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (finish && result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (finish && result) begin
            m_tdata_reg <= kept ? sym_reg : 8'd0;
            m_tuser_reg <= kept;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// File: rtl/snpcmf_checker.sv
// port-level checks of the column mask filter and their binding
`default_nettype none

module snpcmf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // no result straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // a result without a kept byte only closes a sequence and carries zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("empty result not at end of sequence");

    // a line feed never takes a column so is never kept
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata != snpcmf_pkg::CHAR_LF)
        else $error("line feed kept");

endmodule

bind snp_column_mask_filter_unit snpcmf_checker u_snpcmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the alignment column mask filter
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // small stores keep the post-reset sweep short and make the store-full case reachable
    localparam int unsigned STORE_DEPTH     = 16;
    localparam int unsigned RANDOM_REQUESTS = 800;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned GEN_SPAN        = STORE_DEPTH + 4;

    // one request on the input stream
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] symbol;
        logic       last;
    } column_req_t;

    // one filtered result
    typedef struct packed {
        logic [7:0] sym;
        logic       kept;
        logic       eor;
    } column_out_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic [1:0] s_tuser  = snpcmf_pkg::MODE_NONE;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    column_req_t pending_requests[$];
    column_out_t expected_columns[$];

    // predicted state of the block
    logic [7:0]  ref_bytes [STORE_DEPTH];
    logic        usable    [STORE_DEPTH] = '{default: 1'b1};
    logic        varies    [STORE_DEPTH] = '{default: 1'b0};
    int unsigned col_pos = 0;
    int unsigned ref_len = 0;

    // generator's view of the last reference it sent
    logic [7:0]  gen_ref [GEN_SPAN];
    int unsigned gen_len = 0;

    int unsigned total_requests  = 0;
    int unsigned active_requests = 0;
    int unsigned accepted_count  = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    snp_column_mask_filter_unit #(
        .MAX_POSITIONS(STORE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // letters fold to lower case, anything else compares as it is
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= snpcmf_pkg::CHAR_A_UPPER && c <= snpcmf_pkg::CHAR_Z_UPPER) begin
            return c + snpcmf_pkg::CASE_OFFSET[7:0];
        end
        return c;
    endfunction

    // update the predicted masks for one accepted request and queue any result
    function automatic void predict_column(input logic [1:0] mode, input logic [7:0] sym,
                                           input logic last);
        int unsigned p;
        logic        kept;
        column_out_t res;
        p    = col_pos;
        kept = 1'b0;
        if (mode != snpcmf_pkg::MODE_NONE) begin
            if (sym != snpcmf_pkg::CHAR_LF) begin
                if (mode == snpcmf_pkg::MODE_REF) begin
                    if (p < STORE_DEPTH) begin
                        ref_bytes[p] = sym;
                        ref_len      = p + 1;
                    end
                end else if (p < ref_len && p < STORE_DEPTH) begin
                    if (mode == snpcmf_pkg::MODE_MASK) begin
                        if (usable[p]) begin
                            if (sym == snpcmf_pkg::CHAR_N_UPPER ||
                                sym == snpcmf_pkg::CHAR_N_LOWER) begin
                                usable[p] = 1'b0;
                            end else if (fold_case(sym) != fold_case(ref_bytes[p])) begin
                                varies[p] = 1'b1;
                            end
                        end
                    end else begin
                        kept = usable[p] && varies[p];
                    end
                end
                if (p < STORE_DEPTH) begin
                    col_pos = p + 1;
                end
            end
            if (last) begin
                col_pos = 0;
            end
            if (mode == snpcmf_pkg::MODE_FILTER && (kept || last)) begin
                res.sym  = kept ? sym : 8'd0;
                res.kept = kept;
                res.eor  = last;
                expected_columns.insert(expected_columns.size(), res);
            end
        end
    endfunction

    task automatic add_request(input logic [1:0] mode, input logic [7:0] sym, input logic last);
        column_req_t req;
        req.mode   = mode;
        req.symbol = sym;
        req.last   = last;
        pending_requests.insert(pending_requests.size(), req);
        if (mode != snpcmf_pkg::MODE_NONE) begin
            active_requests++;
        end
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1) == 0) begin
            return 8'($urandom_range(snpcmf_pkg::CHAR_Z_UPPER, snpcmf_pkg::CHAR_A_UPPER));
        end
        return 8'($urandom_range(snpcmf_pkg::CHAR_Z_LOWER, snpcmf_pkg::CHAR_A_LOWER));
    endfunction

    // sample byte derived from the reference: mostly equal, sometimes case swapped or changed
    function automatic logic [7:0] vary_symbol(input logic [7:0] base);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            return base;
        end else if (roll < 80) begin
            if (fold_case(base) >= snpcmf_pkg::CHAR_A_LOWER &&
                fold_case(base) <= snpcmf_pkg::CHAR_Z_LOWER) begin
                return base ^ snpcmf_pkg::CASE_OFFSET[7:0];
            end
            return base;
        end else if (roll < 88) begin
            return random_letter();
        end else if (roll < 90) begin
            return ($urandom_range(1) == 0) ? snpcmf_pkg::CHAR_N_UPPER
                                            : snpcmf_pkg::CHAR_N_LOWER;
        end
        return 8'($urandom_range(255));
    endfunction

    // one well-formed sequence with stray line feeds, closed by last
    task automatic add_sequence(input logic [1:0] mode, input int unsigned len);
        logic [7:0] sym;
        logic       closing;
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(24) == 0) begin
                add_request(mode, snpcmf_pkg::CHAR_LF, 1'b0);
            end
            if (mode == snpcmf_pkg::MODE_REF) begin
                sym        = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : random_letter();
                gen_ref[i] = sym;
            end else begin
                sym = vary_symbol(gen_ref[i]);
            end
            closing = (i == len - 1);
            if (closing && $urandom_range(9) == 0) begin
                add_request(mode, sym, 1'b0);
                add_request(mode, snpcmf_pkg::CHAR_LF, 1'b1);
            end else begin
                add_request(mode, sym, closing);
            end
        end
    endtask

    // idle rates by phase of the run
    always_comb begin
        if (accepted_count * 3 < total_requests) begin
            send_idle_pct = 29;
            recv_idle_pct = 60;
        end else if (accepted_count * 3 < total_requests * 2) begin
            send_idle_pct = 60;
            recv_idle_pct = 29;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // request driver
    always @(posedge aclk) begin
        column_req_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_column(s_tuser, s_tdata, s_tlast);
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.symbol;
                    s_tuser  <= req.mode;
                    s_tlast  <= req.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        column_out_t seen;
        column_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.sym  = m_tdata;
                seen.kept = m_tuser;
                seen.eor  = m_tlast;
                if (expected_columns.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: symbol %h kept %b eor %b",
                                 seen.sym, seen.kept, seen.eor);
                    end
                end else begin
                    want = expected_columns.pop_front();
                    if (seen != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected symbol %h kept %b eor %b, got %h %b %b",
                                     want.sym, want.kept, want.eor,
                                     seen.sym, seen.kept, seen.eor);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("snp_column_mask_filter_unit test failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        logic [7:0]  ref_text [17];
        int unsigned random_start;
        int unsigned roll;
        int unsigned noise_len;

        // reference with letter-range boundaries, odd bytes, one byte past the store end
        ref_text = '{"A", "c", "G", "t", "N", "-", 8'h00, 8'hFF, "z", "Z", "a", "@", "[",
                     8'h60, "{", "T", "Q"};

        // mask and filter before any reference: all beyond the reference length
        add_request(snpcmf_pkg::MODE_MASK, "A", 1'b0);
        add_request(snpcmf_pkg::MODE_FILTER, "C", 1'b1);

        // full reference load, with a line feed and an ignored request carrying last
        for (int unsigned i = 0; i < 17; i++) begin
            add_request(snpcmf_pkg::MODE_REF, ref_text[i], i == 16);
            if (i == 3) begin
                add_request(snpcmf_pkg::MODE_REF, snpcmf_pkg::CHAR_LF, 1'b0);
            end
            if (i == 7) begin
                add_request(snpcmf_pkg::MODE_NONE, 8'hA5, 1'b1);
            end
            if (i < STORE_DEPTH) begin
                gen_ref[i] = ref_text[i];
            end
        end
        gen_ref[16] = "A";
        gen_ref[17] = "c";
        gen_ref[18] = "G";
        gen_ref[19] = "t";
        gen_len     = STORE_DEPTH;

        // case-blind match, an n, letter and non-letter differences, line feed closing
        add_request(snpcmf_pkg::MODE_MASK, "a", 1'b0);
        add_request(snpcmf_pkg::MODE_MASK, "C", 1'b0);
        add_request(snpcmf_pkg::MODE_MASK, "n", 1'b0);
        add_request(snpcmf_pkg::MODE_MASK, "x", 1'b0);
        add_request(snpcmf_pkg::MODE_MASK, 8'h01, 1'b0);
        add_request(snpcmf_pkg::MODE_MASK, snpcmf_pkg::CHAR_LF, 1'b1);

        // filter: unchanged columns, the n column, two kept columns, line feed closing
        add_request(snpcmf_pkg::MODE_FILTER, "A", 1'b0);
        add_request(snpcmf_pkg::MODE_FILTER, "c", 1'b0);
        add_request(snpcmf_pkg::MODE_FILTER, "g", 1'b0);
        add_request(snpcmf_pkg::MODE_FILTER, "X", 1'b0);
        add_request(snpcmf_pkg::MODE_FILTER, 8'h7E, 1'b0);
        add_request(snpcmf_pkg::MODE_FILTER, snpcmf_pkg::CHAR_LF, 1'b1);

        // random sequences, mostly well formed, with some noise
        random_start = active_requests;
        while (active_requests - random_start < RANDOM_REQUESTS) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                gen_len = $urandom_range(STORE_DEPTH + 2, 1);
                add_sequence(snpcmf_pkg::MODE_REF, gen_len);
            end else if (roll < 40) begin
                add_sequence(snpcmf_pkg::MODE_MASK, $urandom_range(gen_len + 2, 1));
            end else if (roll < 88) begin
                add_sequence(snpcmf_pkg::MODE_FILTER, $urandom_range(gen_len + 2, 1));
            end else begin
                noise_len = $urandom_range(6, 1);
                for (int unsigned k = 0; k < noise_len; k++) begin
                    add_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                                $urandom_range(3) == 0);
                end
            end
        end
        total_requests = pending_requests.size();

        // reset
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every request to be taken and every result to arrive
        while (accepted_count != total_requests) @(posedge aclk);
        while (expected_columns.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("snp_column_mask_filter_unit test passed");
        end else begin
            $display("snp_column_mask_filter_unit test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/snpcmf_pkg.sv
rtl/snpcmf_ref_store.sv
rtl/snpcmf_mask_store.sv
rtl/snp_column_mask_filter_unit.sv
rtl/snpcmf_checker.sv
tb/sv/testbench.sv
